// ===== sv/ssec_pkg.sv =====
`default_nettype none
package ssec_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int CFG_W              = 32;
    localparam int CFG_IDX_W          = 2;

    localparam logic [CFG_IDX_W-1:0] REG_EDGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_HIGH = 2'd1;

    localparam logic [CFG_W-1:0] EDGE_LOW_RST  = 32'd0;
    localparam logic [CFG_W-1:0] EDGE_HIGH_RST = 32'd65536;

    typedef enum logic [1:0] {
        ORD_CUBIC   = 2'd0,
        ORD_QUINTIC = 2'd1,
        ORD_SEPTIC  = 2'd2
    } t_order;

    // Control that travels alongside each item through the pipeline.
    typedef struct packed {
        logic   valid;
        t_order order;
        logic   degen;
        logic   degen_one;
    } t_ctl;

endpackage
`default_nettype wire

// ===== sv/ssec_in_if.sv =====
`default_nettype none
interface ssec_in_if #(
    parameter int PW = 32
);
    logic          valid;
    logic          ready;
    logic [1:0]    curve_order;
    logic [PW-1:0] position;

    modport source (output valid, output curve_order, output position, input ready);
    modport sink (input valid, input curve_order, input position, output ready);
endinterface
`default_nettype wire

// ===== sv/ssec_out_if.sv =====
`default_nettype none
interface ssec_out_if #(
    parameter int FB = 16
);
    logic        valid;
    logic        ready;
    logic [FB:0] eased_value;
    logic        degenerate;

    modport source (output valid, output eased_value, output degenerate, input ready);
    modport sink (input valid, input eased_value, input degenerate, output ready);
endinterface
`default_nettype wire

// ===== sv/ssec_cfg_if.sv =====
`default_nettype none
interface ssec_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ssec_scale.sv =====
`default_nettype none
module ssec_scale #(
    parameter int POSITION_WIDTH = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_valid,
    input  wire logic [1:0]                i_order,
    input  wire logic [POSITION_WIDTH-1:0] i_position,
    input  wire logic [POSITION_WIDTH-1:0] i_edge_low,
    input  wire logic [POSITION_WIDTH-1:0] i_edge_high,
    output ssec_pkg::t_ctl                 o_ctl,
    output logic [FRACTION_BITS:0]         o_t
);
    import ssec_pkg::*;

    localparam int D = POSITION_WIDTH + 1;
    localparam int F = FRACTION_BITS;
    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

    // Stage A: differences.
    logic signed [D-1:0] r_diff, r_span;
    t_ctl                r_ctl_a;
    // Stage B: magnitudes and signs.
    logic [D-1:0]        r_md, r_ms;
    logic                r_bad_sign, r_dz, r_sz, r_nd;
    t_ctl                r_ctl_b;
    // Divider stages, index 0 is the entry.
    logic [D-1:0]        r_rem [0:F];
    logic [D-1:0]        r_div [0:F];
    logic [F-1:0]        r_q   [0:F];
    logic                r_pre [0:F];
    logic                r_pre_one [0:F];
    t_ctl                r_ctl [0:F];

    logic signed [D-1:0] n_diff, n_span;
    logic [D-1:0]        n_md, n_ms;

    assign n_diff = {i_position[POSITION_WIDTH-1], i_position}
                  - {i_edge_low[POSITION_WIDTH-1], i_edge_low};
    assign n_span = {i_edge_high[POSITION_WIDTH-1], i_edge_high}
                  - {i_edge_low[POSITION_WIDTH-1], i_edge_low};
    assign n_md   = r_diff[D-1] ? D'(-r_diff) : r_diff;
    assign n_ms   = r_span[D-1] ? D'(-r_span) : r_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a.valid <= 1'b0;
            r_ctl_b.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl_a.valid <= i_valid;
            r_ctl_b.valid <= r_ctl_a.valid;
        end
        if (i_adv) begin
            r_diff            <= n_diff;
            r_span            <= n_span;
            r_ctl_a.order     <= t_order'(i_order);
            r_ctl_a.degen     <= 1'b0;
            r_ctl_a.degen_one <= 1'b0;
            r_md              <= n_md;
            r_ms              <= n_ms;
            r_nd              <= r_diff[D-1];
            r_bad_sign        <= r_diff[D-1] != r_span[D-1];
            r_dz              <= r_diff == '0;
            r_sz              <= r_span == '0;
            r_ctl_b.order     <= r_ctl_a.order;
            r_ctl_b.degen     <= 1'b0;
            r_ctl_b.degen_one <= 1'b0;
        end
    end

    // Entry of the divider: settle the out-of-span and degenerate cases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl[0].valid <= r_ctl_b.valid;
        end
        if (i_adv) begin
            r_ctl[0].order     <= r_ctl_b.order;
            r_ctl[0].degen     <= r_sz;
            r_ctl[0].degen_one <= !r_dz && !r_nd;
            r_rem[0]           <= r_md;
            r_div[0]           <= r_ms;
            r_q[0]             <= '0;
            r_pre[0]           <= r_dz || r_bad_sign || (r_md >= r_ms);
            r_pre_one[0]       <= !(r_dz || r_bad_sign);
        end
    end

    // One quotient bit per stage by restoring division.
    for (genvar k = 1; k <= F; k++) begin : g_div
        logic [D:0] n_sh;
        logic       n_ge;
        assign n_sh = {r_rem[k-1], 1'b0};
        assign n_ge = n_sh >= {1'b0, r_div[k-1]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].valid <= 1'b0;
            end else if (i_adv) begin
                r_ctl[k].valid <= r_ctl[k-1].valid;
            end
            if (i_adv) begin
                r_ctl[k].order     <= r_ctl[k-1].order;
                r_ctl[k].degen     <= r_ctl[k-1].degen;
                r_ctl[k].degen_one <= r_ctl[k-1].degen_one;
                r_rem[k]           <= n_ge ? D'(n_sh - {1'b0, r_div[k-1]}) : D'(n_sh);
                r_div[k]           <= r_div[k-1];
                r_q[k]             <= {r_q[k-1][F-2:0], n_ge};
                r_pre[k]           <= r_pre[k-1];
                r_pre_one[k]       <= r_pre_one[k-1];
            end
        end
    end

    assign o_ctl = r_ctl[F];
    assign o_t   = r_pre[F] ? (r_pre_one[F] ? T_ONE : '0) : {1'b0, r_q[F]};

endmodule
`default_nettype wire

// ===== sv/ssec_poly.sv =====
`default_nettype none
module ssec_poly #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  ssec_pkg::t_ctl          i_ctl,
    input  wire logic [FRACTION_BITS:0] i_t,
    output logic                    o_valid,
    output logic [FRACTION_BITS:0]  o_value,
    output logic                    o_degen
);
    import ssec_pkg::*;

    localparam int F = FRACTION_BITS;
    // Intermediates stay within plus or minus 128 in real terms.
    localparam int W = F + 9;
    localparam logic signed [W-1:0] K1  = W'(1)  << F;
    localparam logic signed [W-1:0] K3  = W'(3)  << F;
    localparam logic signed [W-1:0] K10 = W'(10) << F;
    localparam logic signed [W-1:0] K15 = W'(15) << F;
    localparam logic signed [W-1:0] K35 = W'(35) << F;
    localparam logic signed [W-1:0] K70 = W'(70) << F;
    localparam logic signed [W-1:0] K84 = W'(84) << F;
    localparam logic signed [2*W-1:0] RND = (2*W)'((64'd1 << F) - 64'd1);

    // Fixed-point product truncated toward zero.
    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        logic signed [2*W-1:0] s;
        p = a * b;
        s = p[2*W-1] ? (p + RND) : p;
        return W'(s >>> F);
    endfunction

    t_ctl                r_c1, r_c2, r_c3, r_c4;
    logic signed [W-1:0] r_t1, r_t2, r_u1;
    logic signed [W-1:0] r_tb, r_t3, r_r0b, r_u, r_u2;
    logic signed [W-1:0] r_t4, r_r0c, r_r1c, r_u2c;
    logic signed [W-1:0] r_r0d, r_r1d, r_r2d;
    logic                r_ov, r_odg;
    logic [F:0]          r_oval;

    logic signed [W-1:0] n_t, n_r;
    logic [F:0]          n_val;

    assign n_t = signed'(W'(i_t));

    always_comb begin
        case (r_c4.order)
            ORD_CUBIC:   n_r = r_r0d;
            ORD_QUINTIC: n_r = r_r1d;
            ORD_SEPTIC:  n_r = r_r2d;
            default:     n_r = '0;
        endcase
        if (r_c4.degen) begin
            n_val = r_c4.degen_one ? K1[F:0] : '0;
        end else if (n_r < 0) begin
            n_val = '0;
        end else if (n_r > K1) begin
            n_val = K1[F:0];
        end else begin
            n_val = n_r[F:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
            r_c2.valid <= 1'b0;
            r_c3.valid <= 1'b0;
            r_c4.valid <= 1'b0;
            r_ov       <= 1'b0;
        end else if (i_adv) begin
            r_c1.valid <= i_ctl.valid;
            r_c2.valid <= r_c1.valid;
            r_c3.valid <= r_c2.valid;
            r_c4.valid <= r_c3.valid;
            r_ov       <= r_c4.valid;
        end
        if (i_adv) begin
            r_c1.order <= i_ctl.order;  r_c1.degen <= i_ctl.degen;
            r_c1.degen_one <= i_ctl.degen_one;
            r_c2.order <= r_c1.order;   r_c2.degen <= r_c1.degen;
            r_c2.degen_one <= r_c1.degen_one;
            r_c3.order <= r_c2.order;   r_c3.degen <= r_c2.degen;
            r_c3.degen_one <= r_c2.degen_one;
            r_c4.order <= r_c3.order;   r_c4.degen <= r_c3.degen;
            r_c4.degen_one <= r_c3.degen_one;
            // Powers of t and the innermost septic term.
            r_t1  <= n_t;
            r_t2  <= qmul(n_t, n_t);
            r_u1  <= qmul(n_t, K70 - (n_t <<< 4) - (n_t <<< 2));
            // Cubic result, quintic and septic inner terms.
            r_tb  <= r_t1;
            r_t3  <= qmul(r_t2, r_t1);
            r_r0b <= qmul(r_t2, K3 - (r_t1 <<< 1));
            r_u   <= qmul(r_t1, (r_t1 <<< 2) + (r_t1 <<< 1) - K15);
            r_u2  <= qmul(r_t1, r_u1 - K84);
            r_t4  <= qmul(r_t3, r_tb);
            r_r1c <= qmul(r_t3, r_u + K10);
            r_r0c <= r_r0b;
            r_u2c <= r_u2;
            r_r2d <= qmul(r_t4, r_u2c + K35);
            r_r1d <= r_r1c;
            r_r0d <= r_r0c;
            r_oval <= n_val;
            r_odg  <= r_c4.degen;
        end
    end

    assign o_valid = r_ov;
    assign o_value = r_oval;
    assign o_degen = r_odg;

endmodule
`default_nettype wire

// ===== sv/smoothstep_easing_curve.sv =====
`default_nettype none
// Smoothstep easing curve. Each position is scaled into the span between the
// edge_low and edge_high registers as a Q(FRACTION_BITS) value clamped to 0..1,
// and the cubic, quintic or septic smoothstep selected by curve_order is
// evaluated on it; curve_order 3 returns zero when the edges differ. Equal
// edges give 1.0 for positions above edge_low, otherwise 0, with degenerate
// set. One item is accepted every cycle while the output is not stalled. The
// restoring divider resolves one quotient bit per stage and is followed by a
// five-stage multiplier chain. A stall at the output halts the whole pipeline.
// Edge registers are written through the configuration channel, which is
// always ready, and must only be changed while no item is in flight.
module smoothstep_easing_curve #(
    parameter int POSITION_WIDTH = ssec_pkg::POSITION_WIDTH_DEF,
    parameter int FRACTION_BITS  = ssec_pkg::FRACTION_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssec_in_if.sink    i_in,
    ssec_out_if.source o_out,
    ssec_cfg_if.sink   i_cfg
);
    import ssec_pkg::*;

    localparam int P = POSITION_WIDTH;
    localparam int F = FRACTION_BITS;

    logic [CFG_W-1:0] r_edge_low, r_edge_high;
    logic [P-1:0]     n_e0, n_e1;
    logic             n_adv;
    t_ctl             n_ctl;
    logic [F:0]       n_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_low  <= EDGE_LOW_RST;
            r_edge_high <= EDGE_HIGH_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_EDGE_LOW) begin
                r_edge_low <= i_cfg.data;
            end
            if (i_cfg.index == REG_EDGE_HIGH) begin
                r_edge_high <= i_cfg.data;
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    // Edges are taken from the low position-width bits; a wider position
    // sees the register zero-extended.
    if (P <= CFG_W) begin : g_narrow
        assign n_e0 = r_edge_low[P-1:0];
        assign n_e1 = r_edge_high[P-1:0];
    end else begin : g_wide
        assign n_e0 = P'(r_edge_low);
        assign n_e1 = P'(r_edge_high);
    end

    assign n_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = n_adv;

    ssec_scale #(
        .POSITION_WIDTH (P),
        .FRACTION_BITS  (F)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (n_adv),
        .i_valid     (i_in.valid),
        .i_order     (i_in.curve_order),
        .i_position  (i_in.position),
        .i_edge_low  (n_e0),
        .i_edge_high (n_e1),
        .o_ctl       (n_ctl),
        .o_t         (n_t)
    );

    ssec_poly #(
        .FRACTION_BITS (F)
    ) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (n_adv),
        .i_ctl   (n_ctl),
        .i_t     (n_t),
        .o_valid (o_out.valid),
        .o_value (o_out.eased_value),
        .o_degen (o_out.degenerate)
    );

`ifndef SYNTH
    localparam logic [F:0] A_ONE = {1'b1, {F{1'b0}}};

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.eased_value <= A_ONE))
        else $error("eased value above one");

    a_degen_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |->
        (o_out.eased_value == '0 || o_out.eased_value == A_ONE))
        else $error("degenerate result is neither zero nor one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid straight after reset");
`endif

endmodule
`default_nettype wire

// ===== bench/smoothstep_easing_curve_checker.sv =====
`default_nettype none
module smoothstep_easing_curve_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_in_order,
    input  wire logic [31:0] i_in_position,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [16:0] i_out_eased,
    input  wire logic        i_out_degen,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssec_pkg::*;

    localparam longint Q1 = 64'sd65536;

    typedef struct packed {
        logic [16:0] eased;
        logic        degen;
    } t_curve_result;

    t_curve_result eased_queue[$];
    logic signed [31:0] lo_edge, hi_edge;

    function automatic longint fx_mul(longint a, longint b);
        longint ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb) >>> 16;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic t_curve_result predict_ease(logic [1:0] ord, logic signed [31:0] x);
        longint d, s, md, ms, rem, q, t, t2, t3, t4, r;
        t_curve_result res;
        d = longint'(x) - longint'(lo_edge);
        s = longint'(hi_edge) - longint'(lo_edge);
        res.degen = 1'b0;
        if (s == 0) begin
            res.degen = 1'b1;
            res.eased = (d > 0) ? 17'h10000 : 17'h0;
            return res;
        end
        md = (d < 0) ? -d : d;
        ms = (s < 0) ? -s : s;
        if (d == 0 || ((d < 0) != (s < 0))) begin
            t = 0;
        end else if (md >= ms) begin
            t = Q1;
        end else begin
            rem = md;
            q = 0;
            for (int i = 0; i < 16; i++) begin
                rem = rem <<< 1;
                q = q <<< 1;
                if (rem >= ms) begin
                    rem = rem - ms;
                    q = q | 1;
                end
            end
            t = q;
        end
        t2 = fx_mul(t, t);
        t3 = fx_mul(t2, t);
        t4 = fx_mul(t3, t);
        case (ord)
            ORD_CUBIC: r = fx_mul(t2, 3 * Q1 - 2 * t);
            ORD_QUINTIC: r = fx_mul(t3, fx_mul(t, 6 * t - 15 * Q1) + 10 * Q1);
            ORD_SEPTIC: r = fx_mul(t4,
                fx_mul(t, fx_mul(t, 70 * Q1 - 20 * t) - 84 * Q1) + 35 * Q1);
            default: r = 0;
        endcase
        if (r < 0) r = 0;
        if (r > Q1) r = Q1;
        res.eased = r[16:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_curve_result want;
        if (!i_rst_n) begin
            lo_edge <= EDGE_LOW_RST;
            hi_edge <= EDGE_HIGH_RST;
            o_fail_count <= 0;
            o_seen <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_EDGE_LOW) lo_edge <= i_cfg_data;
                else if (i_cfg_index == REG_EDGE_HIGH) hi_edge <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                eased_queue.push_back(predict_ease(i_in_order, i_in_position));
            if (i_out_valid && i_out_ready) begin
                o_seen <= o_seen + 1;
                if (eased_queue.size() == 0) begin
                    $display("%0t: unexpected result eased=%0d degen=%0b",
                             $time, i_out_eased, i_out_degen);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = eased_queue.pop_front();
                    if (want.eased !== i_out_eased || want.degen !== i_out_degen) begin
                        $display({"%0t: mismatch expected eased=%0d degen=%0b",
                                  " actual eased=%0d degen=%0b"},
                                 $time, want.eased, want.degen, i_out_eased, i_out_degen);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= eased_queue.size();
    end
endmodule
`default_nettype wire

// ===== bench/smoothstep_easing_curve_tb.sv =====
`default_nettype none
module smoothstep_easing_curve_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssec_pkg::*;

    logic i_clk, i_rst_n;
    int fail_count, pending, seen;
    logic rx_stall_mode;

    ssec_in_if #(.PW(32)) in_ch();
    ssec_out_if #(.FB(16)) out_ch();
    ssec_cfg_if cfg_ch();

    smoothstep_easing_curve i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    smoothstep_easing_curve_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_in_order(in_ch.curve_order), .i_in_position(in_ch.position),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_out_eased(out_ch.eased_value), .i_out_degen(out_ch.degenerate),
        .i_cfg_valid(cfg_ch.valid), .i_cfg_ready(cfg_ch.ready),
        .i_cfg_index(cfg_ch.index), .i_cfg_data(cfg_ch.data),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver alternates between stretches of random stalls and full flow.
    initial begin
        int cnt;
        out_ch.ready = 1'b0;
        rx_stall_mode = 1'b0;
        cnt = 0;
        forever begin
            @(posedge i_clk);
            if (cnt == 0) begin
                rx_stall_mode <= 1'($urandom_range(0, 1));
                cnt = $urandom_range(10, 80);
            end
            cnt--;
            out_ch.ready <= rx_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    task automatic send_item(logic [1:0] ord, logic [31:0] pos);
        in_ch.valid <= 1'b1;
        in_ch.curve_order <= ord;
        in_ch.position <= pos;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic pause_sender(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_edge(logic [1:0] idx, logic [31:0] val);
        in_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every expected result has come back before touching registers.
    task automatic drain_pipe();
        int guard;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_position(logic [31:0] lo, logic [31:0] hi);
        logic signed [63:0] a, b, span;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return lo;
            2: return hi;
            3: return lo + $urandom_range(0, 3) - 1;
            4: return hi + $urandom_range(0, 3) - 1;
            5: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} ^ {32{$urandom_range(0, 1) == 1}};
            default: begin
                a = $signed(lo);
                b = $signed(hi);
                span = (b > a) ? b - a : a - b;
                if (span == 0) return lo + $urandom_range(0, 2) - 1;
                return 32'(((b > a) ? a : b) + ({$urandom(), $urandom()} % (span + 1)));
            end
        endcase
    endfunction

    logic [31:0] lo_list[7] = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1000, 32'd5,
                                32'h8000_0000, 32'd1000};
    logic [31:0] hi_list[7] = '{32'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3000, 32'd5,
                                32'h8000_0000, 32'd1016};

    initial begin
        logic [31:0] lo, hi;
        logic [1:0] ord;
        int sent;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.curve_order = '0;
        in_ch.position = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset edges: every order including the unused one.
        for (int o = 0; o < 4; o++) begin
            send_item(o[1:0], 32'd0);
            send_item(o[1:0], 32'd32768);
            send_item(o[1:0], 32'd65536);
            send_item(o[1:0], 32'h8000_0000);
            send_item(o[1:0], 32'h7FFF_FFFF);
        end
        drain_pipe();
        // Equal edges, positions on both sides and exactly at the edge.
        write_edge(REG_EDGE_LOW, 32'd77);
        write_edge(REG_EDGE_HIGH, 32'd77);
        send_item(ORD_CUBIC, 32'd76);
        send_item(ORD_QUINTIC, 32'd77);
        send_item(ORD_SEPTIC, 32'd78);
        send_item(2'd3, 32'd78);
        drain_pipe();

        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 7) begin
                lo = lo_list[ph];
                hi = hi_list[ph];
            end else begin
                lo = $urandom();
                hi = $urandom();
            end
            write_edge(REG_EDGE_LOW, lo);
            write_edge(REG_EDGE_HIGH, hi);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 8));
                ord = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                send_item(ord, pick_position(lo, hi));
                sent++;
            end
            drain_pipe();
        end

        $display("Covered %0d random items over eight edge settings, %0d results checked.",
                 sent, seen);
        $display("Edge settings included full-range, reversed, equal and narrow spans.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
